// ===== src/rhns_pkg.sv =====
// ----------------------------------------------------------------------------
// rhns_pkg: shared types and constants for rendezvous node selection
// Widths, djb2 constants, label text hashing tables and register codes.
// ----------------------------------------------------------------------------
package rhns_pkg;

  localparam int LABEL_REGS     = 5;
  localparam int NODE_COUNT_DEF = 5;
  localparam int LABEL_W        = 16;
  localparam int HASH_W         = 64;
  localparam int BYTE_W         = 8;
  localparam int NODE_W         = 3;
  localparam int MAX_DIGITS     = 5;
  localparam int DIGIT_IDX_W    = 3;
  localparam int DIGIT_W        = 4;
  localparam int ACC_W          = 27;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 5;
  localparam int REG_IDX_W      = 3;
  localparam int LABEL_BASE     = 7700;
  localparam int ASCII_ZERO     = 48;

  // v / 10 == (v * RECIP10) >> RECIP10_SHIFT for every 16-bit v
  localparam logic [LABEL_W-1:0] RECIP10       = 16'hCCCD;
  localparam int                 RECIP10_SHIFT = 19;

  localparam logic [HASH_W-1:0] DJB2_START = 64'd5381;

  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [LABEL_W-1:0] label_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LABEL_0 = 3'd0,
    REG_LABEL_1 = 3'd1,
    REG_LABEL_2 = 3'd2,
    REG_LABEL_3 = 3'd3,
    REG_LABEL_4 = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic                  busy;
    logic [LABEL_REGS-1:0] reload;
  } lbl_status_t;

  // digit term (ASCII digit) * 33^k, indexed [k][digit]
  typedef logic [MAX_DIGITS-1:0][9:0][ACC_W-1:0] dterm_tab_t;
  // 5381 * 33^n, indexed by digit count n
  typedef logic [MAX_DIGITS:0][HASH_W-1:0] seed_tab_t;

  function automatic hash_t pow33(input int n);
    hash_t p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = (p << 5) + p;
    end
    return p;
  endfunction

  function automatic label_t label_reset(input int i);
    return LABEL_W'(LABEL_BASE + i);
  endfunction

  function automatic dterm_tab_t build_dterms();
    dterm_tab_t t;
    hash_t      p;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      p = pow33(k);
      for (int d = 0; d < 10; d++) begin
        t[k][d] = ACC_W'(p * HASH_W'(ASCII_ZERO + d));
      end
    end
    return t;
  endfunction

  function automatic seed_tab_t build_seeds();
    seed_tab_t t;
    for (int n = 0; n <= MAX_DIGITS; n++) begin
      t[n] = DJB2_START * pow33(n);
    end
    return t;
  endfunction

  localparam dterm_tab_t DIGIT_TERMS = build_dterms();
  localparam seed_tab_t  SEED_TERMS  = build_seeds();

endpackage

// ===== src/rhns_ifs.sv =====
// ----------------------------------------------------------------------------
// rhns_ifs: valid/ready channels of the node selector
// Name byte channel into the block and chosen node channel out of it.
// ----------------------------------------------------------------------------
interface rhns_in_if import rhns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              name_end;

  modport source (output valid, output name_byte, output name_end, input ready);
  modport sink   (input valid, input name_byte, input name_end, output ready);
endinterface

interface rhns_out_if import rhns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] chosen_node;

  modport source (output valid, output chosen_node, input ready);
  modport sink   (input valid, input chosen_node, output ready);
endinterface

// ===== src/rendezvous_hash_node_select.sv =====
// ----------------------------------------------------------------------------
// rendezvous_hash_node_select: highest-random-weight node selection
// Streams key name bytes through per-node djb2 hashes and names the winner.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one name byte per beat, name_end flags the last byte.
//   out_ch carries one chosen_node beat per name, after its last byte.
//   The cfg_ APB port holds the node labels at byte address 4*i; writes
//   complete in the access phase (psel and penable high), pready is tied high.
// Throughput: one byte per cycle while in_ch.ready is high; every node
//   accumulator is a shift-add. The last byte captures the final hashes,
//   and the max scan loads the output register once it is free.
// Label hashing: the decimal text of a label is hashed one digit per cycle by
//   a small unit per node, so in_ch.ready stays low after a label write
//   until the new prefix is loaded.
// Reset: labels return to 7700..7704 and all prefixes are rehashed; ready
//   stays low after rst_n rises until the rehash is done.
// Stall: a finished result waits in the output register while one more name
//   may complete into the capture stage; bytes stop as soon as both are full.
// ----------------------------------------------------------------------------
module rendezvous_hash_node_select import rhns_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rhns_in_if.sink               in_ch,
  rhns_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  hash_t             prefix     [NODE_COUNT];
  lbl_status_t       status;
  hash_t             node_hash_r [NODE_COUNT];
  hash_t             hash_upd   [NODE_COUNT];
  hash_t             fin_r      [NODE_COUNT];
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [NODE_W-1:0] out_node_r;
  logic [NODE_W-1:0] pick;
  logic              in_fire;
  logic              last_fire;
  logic              out_load;
  logic              s1_adv;

  assign cfg_pready = 1'b1;

  rhns_cfg_regs #(.NODE_COUNT(NODE_COUNT)) u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .prefix  (prefix),
    .status  (status)
  );

  assign out_load     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && out_load;
  assign in_ch.ready  = !status.busy && (!s1_valid_r || out_load);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign last_fire    = in_fire && in_ch.name_end;
  assign s1_valid_nxt = last_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = out_load ? s1_valid_r : out_valid_r;

  always_comb begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      hash_upd[i] = (node_hash_r[i] << 5) + node_hash_r[i] + HASH_W'(in_ch.name_byte);
    end
  end

  // rearm from the prefix after a name ends or a label has been rehashed
  always_ff @(posedge clk) begin
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (status.reload[i] || last_fire) begin
        node_hash_r[i] <= prefix[i];
      end else if (in_fire) begin
        node_hash_r[i] <= hash_upd[i];
      end
      if (last_fire) begin
        fin_r[i] <= hash_upd[i];
      end
    end
  end

  rhns_max_select #(.NODE_COUNT(NODE_COUNT)) u_max_select (
    .hash (fin_r),
    .pick (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_node_r <= pick;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_node = out_node_r;

endmodule

// ===== src/rhns_label_hash.sv =====
// ----------------------------------------------------------------------------
// rhns_label_hash: djb2 of a label's decimal text
// Peels one decimal digit per cycle, least significant first, and sums the
// weighted digit terms; the seed term for the digit count closes the hash.
// ----------------------------------------------------------------------------
module rhns_label_hash import rhns_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  label_t label,
  output logic   busy,
  output logic   done,
  output hash_t  prefix
);

  label_t                 v_r;
  logic [DIGIT_IDX_W-1:0] k_r;
  logic [ACC_W-1:0]       acc_r;
  logic                   busy_r;
  logic                   done_r;
  hash_t                  prefix_r;

  logic [2*LABEL_W-1:0]   prod;
  label_t                 quot;
  label_t                 quot10;
  logic [DIGIT_W-1:0]     digit;
  logic [ACC_W-1:0]       acc_sum;
  logic                   last_digit;

  always_comb begin
    prod       = v_r * RECIP10;
    quot       = LABEL_W'(prod[2*LABEL_W-1:RECIP10_SHIFT]);
    quot10     = (quot << 3) + (quot << 1);
    digit      = DIGIT_W'(v_r - quot10);
    acc_sum    = acc_r + DIGIT_TERMS[k_r][digit];
    last_digit = (quot == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_r && !last_digit;
      done_r <= busy_r && last_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= label;
      k_r   <= '0;
      acc_r <= '0;
    end else if (busy_r) begin
      v_r   <= quot;
      k_r   <= k_r + 1'b1;
      acc_r <= acc_sum;
      if (last_digit) begin
        prefix_r <= SEED_TERMS[k_r + 1'b1] + HASH_W'(acc_sum);
      end
    end
  end

  assign busy   = busy_r | done_r;
  assign done   = done_r;
  assign prefix = prefix_r;

endmodule

// ===== src/rhns_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rhns_cfg_regs: label registers and prefix hash units
// APB register file for the node labels; each write rehashes that label.
// ----------------------------------------------------------------------------
module rhns_cfg_regs import rhns_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output hash_t                 prefix [NODE_COUNT],
  output lbl_status_t           status
);

  label_t                labels_r [LABEL_REGS];
  logic                  init_r;
  logic [REG_IDX_W-1:0]  idx;
  logic                  wr_hit;
  logic [NODE_COUNT-1:0] busy_v;
  logic [NODE_COUNT-1:0] done_v;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_hit = psel && penable && pwrite && (idx <= REG_LABEL_4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
      for (int i = 0; i < LABEL_REGS; i++) begin
        labels_r[i] <= label_reset(i);
      end
    end else begin
      init_r <= 1'b0;
      if (wr_hit) begin
        labels_r[idx] <= pwdata[LABEL_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx <= REG_LABEL_4) begin
      prdata = CFG_DATA_W'(labels_r[idx]);
    end else begin
      prdata = '0;
    end
  end

  for (genvar g = 0; g < NODE_COUNT; g++) begin : g_node
    logic   hit;
    label_t start_label;

    assign hit         = wr_hit && (idx == REG_IDX_W'(g));
    assign start_label = hit ? pwdata[LABEL_W-1:0] : labels_r[g];

    rhns_label_hash u_label_hash (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (init_r | hit),
      .label  (start_label),
      .busy   (busy_v[g]),
      .done   (done_v[g]),
      .prefix (prefix[g])
    );
  end

  always_comb begin
    status.busy   = init_r | (|busy_v);
    status.reload = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      status.reload[i] = done_v[i];
    end
  end

endmodule

// ===== src/rhns_max_select.sv =====
// ----------------------------------------------------------------------------
// rhns_max_select: pick the node with the largest final hash
// Scan in index order; only a strictly greater hash takes over.
// ----------------------------------------------------------------------------
module rhns_max_select import rhns_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  hash_t             hash [NODE_COUNT],
  output logic [NODE_W-1:0] pick
);

  hash_t best;

  always_comb begin
    best = '0;
    pick = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (hash[i] > best) begin
        best = hash[i];
        pick = NODE_W'(i);
      end
    end
  end

endmodule

// ===== src/rhns_checker.sv =====
// ----------------------------------------------------------------------------
// rhns_checker: port-level checks for the node selector
// Output hold under stall, node range and ready gating by label rehashing.
// ----------------------------------------------------------------------------
module rhns_checker import rhns_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [NODE_W-1:0]     chosen_node,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr
);

  logic node_wr;

  assign node_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                   (cfg_paddr[CFG_ADDR_W-1:2] < REG_IDX_W'(NODE_COUNT));

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(chosen_node))
    else $error("result beat dropped or changed while stalled");

  a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> chosen_node < NODE_W'(NODE_COUNT))
    else $error("chosen node outside the node count");

  a_init_gate: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("byte taken before reset labels are hashed");

  a_write_gate: assert property (@(posedge clk) disable iff (!rst_n)
    node_wr |=> !in_ready)
    else $error("byte taken while a label is being rehashed");

endmodule

bind rendezvous_hash_node_select rhns_checker #(.NODE_COUNT(NODE_COUNT)) u_rhns_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .chosen_node (out_ch.chosen_node),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr)
);

// ===== tb/tb_rendezvous_hash_node_select.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rendezvous_hash_node_select: self-checking bench for the node selector
// Streams key names byte by byte, rewrites node labels over the APB port
// between names and mid-name, predicts the winning node with a djb2 model of
// its own and checks every chosen_node beat and every label readback.
// ----------------------------------------------------------------------------
module tb_rendezvous_hash_node_select;
  import rhns_pkg::*;

  localparam int NODES         = NODE_COUNT_DEF;
  localparam int SPARE_REG_IDX = LABEL_REGS;
  localparam int SETTLE        = 12;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASES        = 6;
  localparam int PHASE_BYTES   = 56;

  class node_select_scoreboard;
    logic [LABEL_W-1:0] labels  [LABEL_REGS];
    logic [HASH_W-1:0]  prefix  [LABEL_REGS];
    logic [HASH_W-1:0]  running [LABEL_REGS];
    logic [NODE_W-1:0]  chosen_due[$];
    int mismatches;
    int bytes_seen;
    int names_checked;

    function new();
      for (int i = 0; i < LABEL_REGS; i++) begin
        set_label(i, LABEL_W'(LABEL_BASE + i));
      end
      mismatches    = 0;
      bytes_seen    = 0;
      names_checked = 0;
    endfunction

    // djb2 over the label's decimal text, most significant digit first
    function logic [HASH_W-1:0] label_digits_hash(logic [LABEL_W-1:0] lbl);
      logic [BYTE_W-1:0] digits[MAX_DIGITS];
      logic [HASH_W-1:0] h;
      int n;
      int v;
      n = 0;
      v = lbl;
      do begin
        digits[n] = BYTE_W'(ASCII_ZERO + v % 10);
        v = v / 10;
        n++;
      end while (v != 0);
      h = DJB2_START;
      for (int k = n - 1; k >= 0; k--) begin
        h = (h << 5) + h + HASH_W'(digits[k]);
      end
      return h;
    endfunction

    function void set_label(int idx, logic [LABEL_W-1:0] value);
      if (idx < LABEL_REGS) begin
        labels[idx]  = value;
        prefix[idx]  = label_digits_hash(value);
        running[idx] = prefix[idx];
      end
    endfunction

    function void note_name_byte(logic [BYTE_W-1:0] b, logic last);
      logic [HASH_W-1:0] best;
      logic [NODE_W-1:0] pick;
      bytes_seen++;
      for (int i = 0; i < NODES; i++) begin
        running[i] = (running[i] << 5) + running[i] + HASH_W'(b);
      end
      if (last) begin
        best = '0;
        pick = '0;
        // strictly greater only: ties stay with the lower index
        for (int i = 0; i < NODES; i++) begin
          if (running[i] > best) begin
            best = running[i];
            pick = NODE_W'(i);
          end
        end
        chosen_due.push_back(pick);
        for (int i = 0; i < LABEL_REGS; i++) begin
          running[i] = prefix[i];
        end
      end
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_chosen_node(logic [NODE_W-1:0] got);
      logic [NODE_W-1:0] want;
      if (chosen_due.size() == 0) begin
        flag_mismatch($sformatf("chosen_node %0d with no name pending", got));
      end else begin
        want = chosen_due.pop_front();
        names_checked++;
        if (got !== want) begin
          flag_mismatch($sformatf("chosen_node got %0d want %0d", got, want));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rhns_in_if  in_ch ();
  rhns_out_if out_ch ();

  node_select_scoreboard sb;
  bit hold_req;
  bit in_steady;
  int cycle_count;
  int label_writes;
  int label_settings;

  rendezvous_hash_node_select DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d names outstanding", cycle_count,
             sb.chosen_due.size());
    $display("tb_rendezvous_hash_node_select: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_chosen_node(out_ch.chosen_node);
    end
  end

  // result side: random stalls, steady stretches, one long hold-off on request
  initial begin
    int gap;
    bit steady;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) steady = ~steady;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  function automatic int draw_gap();
    return in_steady ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LABEL_W'($urandom_range(0, 9));
      3:       return LABEL_W'($urandom_range(10, 999));
      default: return LABEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_name_byte();
    if ($urandom_range(0, 11) == 0) return '0;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back beat
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last, input int gap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.name_byte = b;
    in_ch.name_end  = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_name_byte(b, last);
    @(negedge clk);
  endtask

  task automatic push_name(input int len, input bit close);
    for (int k = 0; k < len; k++) begin
      push_byte(pick_name_byte(), close && (k == len - 1), draw_gap());
    end
  endtask

  // drain results, then give the pipeline time to finish a byte in flight
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (sb.chosen_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_ADDR_W'(idx * 4);
    cfg_pwdata  = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_label(idx, data[LABEL_W-1:0]);
    label_writes++;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_labels();
    logic [CFG_DATA_W-1:0] got;
    for (int i = 0; i < LABEL_REGS; i++) begin
      cfg_psel    = 1'b1;
      cfg_penable = 1'b0;
      cfg_pwrite  = 1'b0;
      cfg_paddr   = CFG_ADDR_W'(i * 4);
      @(negedge clk);
      cfg_penable = 1'b1;
      @(posedge clk);
      while (!cfg_pready) @(posedge clk);
      got = cfg_prdata;
      if (got[LABEL_W-1:0] !== sb.labels[i]) begin
        sb.flag_mismatch($sformatf("label %0d read %0d want %0d", i,
                                   got[LABEL_W-1:0], sb.labels[i]));
      end
      @(negedge clk);
      cfg_psel    = 1'b0;
      cfg_penable = 1'b0;
    end
  endtask

  task automatic load_labels(input logic [LABEL_W-1:0] v0, input logic [LABEL_W-1:0] v1,
                             input logic [LABEL_W-1:0] v2, input logic [LABEL_W-1:0] v3,
                             input logic [LABEL_W-1:0] v4);
    apb_write(REG_LABEL_0, CFG_DATA_W'(v0));
    apb_write(REG_LABEL_1, CFG_DATA_W'(v1));
    apb_write(REG_LABEL_2, CFG_DATA_W'(v2));
    apb_write(REG_LABEL_3, CFG_DATA_W'(v3));
    apb_write(REG_LABEL_4, CFG_DATA_W'(v4));
    label_settings++;
    check_labels();
  endtask

  initial begin
    int phase_start;
    sb             = new();
    hold_req       = 1'b0;
    in_steady      = 1'b0;
    label_writes   = 0;
    label_settings = 1;
    rst_n          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.name_byte = '0;
    in_ch.name_end  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset labels: extreme bytes, names that end in a zero byte
    push_byte(8'h00, 1'b1, draw_gap());
    push_byte(8'hFF, 1'b1, draw_gap());
    push_byte(8'h01, 1'b0, draw_gap());
    push_byte(8'h80, 1'b0, draw_gap());
    push_byte(8'h00, 1'b1, draw_gap());
    push_byte(8'h6B, 1'b0, 0);
    push_byte(8'h65, 1'b0, 0);
    push_byte(8'h79, 1'b1, 0);
    wait_idle();
    check_labels();

    // label rewritten mid-name: node 2 drops the bytes hashed so far
    push_byte(8'h61, 1'b0, draw_gap());
    push_byte(8'h62, 1'b0, draw_gap());
    wait_idle();
    apb_write(REG_LABEL_2, '0);
    push_byte(8'h63, 1'b1, draw_gap());
    wait_idle();

    // equal labels tie to node 0; an index past the last label is ignored
    load_labels('0, '0, '0, '0, '0);
    apb_write(SPARE_REG_IDX, 32'h0000_1234);
    check_labels();
    push_byte(8'h55, 1'b1, draw_gap());
    push_byte(8'h00, 1'b1, draw_gap());
    wait_idle();
    load_labels('1, '1, '1, '1, '1);
    push_byte(8'hAA, 1'b0, draw_gap());
    push_byte(8'h7F, 1'b1, draw_gap());
    wait_idle();
    load_labels(16'd0, 16'd9, 16'd10, 16'hFFFF, 16'd12345);
    push_byte(8'h5A, 1'b1, draw_gap());
    push_byte(8'hC3, 1'b0, draw_gap());
    push_byte(8'h3C, 1'b1, draw_gap());
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      // sometimes leave a name open across the label update
      if (p > 0 && $urandom_range(0, 1) == 1) begin
        push_name($urandom_range(1, 5), 1'b0);
      end
      wait_idle();
      if (p == 0) begin
        load_labels(pick_label(), pick_label(), pick_label(), pick_label(), pick_label());
      end else begin
        for (int i = 0; i < LABEL_REGS; i++) begin
          if ($urandom_range(0, 1) == 1) apb_write(i, CFG_DATA_W'(pick_label()));
        end
        label_settings++;
        check_labels();
      end

      if (p == 1) begin
        // receiver holds off while short names pour in back to back
        hold_req  = 1'b1;
        in_steady = 1'b1;
        for (int k = 0; k < 24; k++) push_name($urandom_range(1, 3), 1'b1);
        in_steady = 1'b0;
      end

      phase_start = sb.bytes_seen;
      while (sb.bytes_seen - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 7) == 0) in_steady = ~in_steady;
        if ($urandom_range(0, 15) == 0) push_name($urandom_range(20, 40), 1'b1);
        else push_name($urandom_range(1, 8), 1'b1);
      end
    end

    wait_idle();
    $display("covered %0d name bytes and %0d chosen-node beats", sb.bytes_seen,
             sb.names_checked);
    $display("over %0d label writes in %0d label settings, incl. mid-name updates",
             label_writes, label_settings);
    if (sb.mismatches == 0 && sb.chosen_due.size() == 0) begin
      $display("tb_rendezvous_hash_node_select: PASS");
    end else begin
      $display("tb_rendezvous_hash_node_select: FAIL");
    end
    $finish;
  end

endmodule
